// ===== sv/pwbs_pkg.sv =====
// Package with the shared types and constants of the pulse-width byte sender.
package pwbs_pkg;

   // Number of data bits sent in one frame, LSB first.
   localparam int unsigned BITS_PER_FRAME = 8;

   localparam int unsigned TICK_W = 8;
   localparam int unsigned BIT_IDX_W = 4;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 8;

   // Register indexes on the CSR write channel.
   localparam logic [CSR_IDX_W-1:0] REG_START_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_TOTAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIT_LOW     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_TOTAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_TOTAL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_LOW    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_TOTAL  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_REPEATS     = 3'd7;

   // Register reset values.
   localparam logic [7:0] RST_START_LOW   = 8'd8;
   localparam logic [7:0] RST_START_TOTAL = 8'd16;
   localparam logic [7:0] RST_BIT_LOW     = 8'd4;
   localparam logic [7:0] RST_ONE_TOTAL   = 8'd16;
   localparam logic [7:0] RST_ZERO_TOTAL  = 8'd8;
   localparam logic [7:0] RST_STOP_LOW    = 8'd16;
   localparam logic [7:0] RST_STOP_TOTAL  = 8'd24;
   localparam logic [7:0] RST_REPEATS     = 8'd3;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

endpackage

// ===== sv/pulse_width_byte_sender.sv =====
// Top level of the pulse-width byte sender: single-wire frame transmitter stepped per tick.
//
//   channel  direction  beat contents (low bit first)
//   req      in         start_request, abort_request, data_byte
//   rsp      out        line_level, busy_res, done_res
//   csr      in         csr_index (register), csr_data (value)
//
// Each req beat is one timer tick whose result is captured in the result register; a new
// beat can be taken every cycle while rsp does not stall. The only storage between the two
// sides is the result register, so req_tready is high whenever that register is empty or is
// being drained. Synchronous active-high reset restores the register defaults, idles the
// sequence and drives the line high. A stall on rsp holds the result and stops req intake.
module pulse_width_byte_sender #(
   parameter int unsigned BITS_PER_FRAME = pwbs_pkg::BITS_PER_FRAME
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // start_request [0], abort_request [1], data_byte [9:2], zero fill [15:10]
   input  logic [pwbs_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // line_level [0], busy_res [1], done_res [2], zero fill [7:3]
   output logic [pwbs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pwbs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pwbs_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic [7:0] start_low_ff, start_total_ff, bit_low_ff, one_total_ff;
   logic [7:0] zero_total_ff, stop_low_ff, stop_total_ff, repeats_ff;

   pwbs_pkg::phase_type                  phase_ff, phase_in;
   logic [pwbs_pkg::TICK_W-1:0]          tick_count_ff, tick_count_in;
   logic [pwbs_pkg::BIT_IDX_W-1:0]       bit_index_ff, bit_index_in;
   logic [7:0]                           repeat_count_ff, repeat_count_in;
   logic                                 active_ff, active_in;
   logic [7:0]                           held_byte_ff, held_byte_in;
   logic                                 wire_level_ff, wire_level_in;
   logic                                 done_in;

   logic                                 rsp_valid_ff;
   logic [pwbs_pkg::RSP_DATA_W-1:0]      rsp_data_ff;

   logic                                 req_fire;
   logic                                 start_req, abort_req;
   logic [7:0]                           data_byte;
   logic [pwbs_pkg::TICK_W-1:0]          tick_inc;
   logic [pwbs_pkg::BIT_IDX_W-1:0]       bit_next;
   logic [7:0]                           repeat_next;
   logic                                 cur_bit;
   logic [7:0]                           bit_total;

   assign start_req = req_tdata[0];
   assign abort_req = req_tdata[1];
   assign data_byte = req_tdata[9:2];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign tick_inc    = tick_count_ff + 8'd1;
   assign bit_next    = bit_index_ff + 4'd1;
   assign repeat_next = repeat_count_ff + 8'd1;

   always_comb begin
      active_in       = active_ff;
      held_byte_in    = held_byte_ff;
      phase_in        = phase_ff;
      tick_count_in   = tick_count_ff;
      bit_index_in    = bit_index_ff;
      repeat_count_in = repeat_count_ff;
      wire_level_in   = wire_level_ff;
      done_in         = 1'b0;
      cur_bit         = held_byte_ff[bit_index_ff[2:0]];
      bit_total       = cur_bit ? one_total_ff : zero_total_ff;

      if (abort_req) begin
         active_in = 1'b0;
      end else if (start_req && !active_ff) begin
         active_in    = 1'b1;
         held_byte_in = data_byte;
      end

      if (!active_in) begin
         phase_in        = pwbs_pkg::PH_IDLE;
         tick_count_in   = '0;
         bit_index_in    = '0;
         repeat_count_in = '0;
      end else begin
         case (phase_ff)
            pwbs_pkg::PH_IDLE: begin
               wire_level_in = 1'b1;
               tick_count_in = '0;
               phase_in      = pwbs_pkg::PH_START;
            end
            pwbs_pkg::PH_START: begin
               tick_count_in = tick_inc;
               if (tick_inc <= start_low_ff) begin
                  wire_level_in = 1'b0;
               end else if (tick_inc < start_total_ff) begin
                  wire_level_in = 1'b1;
               end else begin
                  tick_count_in = '0;
                  bit_index_in  = '0;
                  phase_in      = pwbs_pkg::PH_DATA;
               end
            end
            pwbs_pkg::PH_DATA: begin
               tick_count_in = tick_inc;
               if (tick_inc <= bit_low_ff) begin
                  wire_level_in = 1'b0;
               end else if (tick_inc < bit_total) begin
                  wire_level_in = 1'b1;
               end else begin
                  tick_count_in = '0;
                  bit_index_in  = bit_next;
                  if (bit_next >= 4'(BITS_PER_FRAME)) begin
                     bit_index_in = '0;
                     phase_in     = pwbs_pkg::PH_STOP;
                  end
               end
            end
            pwbs_pkg::PH_STOP: begin
               tick_count_in = tick_inc;
               if (tick_inc <= stop_low_ff) begin
                  wire_level_in = 1'b0;
               end else if (tick_inc < stop_total_ff) begin
                  wire_level_in = 1'b1;
               end else begin
                  tick_count_in   = '0;
                  repeat_count_in = repeat_next;
                  phase_in        = pwbs_pkg::PH_IDLE;
                  if (repeat_next >= repeats_ff) begin
                     repeat_count_in = '0;
                     active_in       = 1'b0;
                     done_in         = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = pwbs_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_ff   <= pwbs_pkg::RST_START_LOW;
         start_total_ff <= pwbs_pkg::RST_START_TOTAL;
         bit_low_ff     <= pwbs_pkg::RST_BIT_LOW;
         one_total_ff   <= pwbs_pkg::RST_ONE_TOTAL;
         zero_total_ff  <= pwbs_pkg::RST_ZERO_TOTAL;
         stop_low_ff    <= pwbs_pkg::RST_STOP_LOW;
         stop_total_ff  <= pwbs_pkg::RST_STOP_TOTAL;
         repeats_ff     <= pwbs_pkg::RST_REPEATS;
      end else if (csr_valid) begin
         case (csr_index)
            pwbs_pkg::REG_START_LOW:   start_low_ff   <= csr_data;
            pwbs_pkg::REG_START_TOTAL: start_total_ff <= csr_data;
            pwbs_pkg::REG_BIT_LOW:     bit_low_ff     <= csr_data;
            pwbs_pkg::REG_ONE_TOTAL:   one_total_ff   <= csr_data;
            pwbs_pkg::REG_ZERO_TOTAL:  zero_total_ff  <= csr_data;
            pwbs_pkg::REG_STOP_LOW:    stop_low_ff    <= csr_data;
            pwbs_pkg::REG_STOP_TOTAL:  stop_total_ff  <= csr_data;
            pwbs_pkg::REG_REPEATS:     repeats_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= pwbs_pkg::PH_IDLE;
         tick_count_ff   <= '0;
         bit_index_ff    <= '0;
         repeat_count_ff <= '0;
         active_ff       <= 1'b0;
         held_byte_ff    <= '0;
         wire_level_ff   <= 1'b1;
      end else if (req_fire) begin
         phase_ff        <= phase_in;
         tick_count_ff   <= tick_count_in;
         bit_index_ff    <= bit_index_in;
         repeat_count_ff <= repeat_count_in;
         active_ff       <= active_in;
         held_byte_ff    <= held_byte_in;
         wire_level_ff   <= wire_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {5'b0, done_in, active_in, wire_level_in};
      end
   end

   // An abort beat always leaves the sequencer idle and inactive.
   a_abort_idles: assert property (@(posedge clock) disable iff (reset)
      (req_fire && abort_req) |=> (!active_ff && phase_ff == pwbs_pkg::PH_IDLE))
      else $error("abort did not idle the sequencer");

   // While inactive the sequence counters stay cleared.
   a_inactive_clear: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (phase_ff == pwbs_pkg::PH_IDLE && tick_count_ff == '0
                      && bit_index_ff == '0 && repeat_count_ff == '0))
      else $error("sequence state not cleared while inactive");

   // A pending done result matches an idle, inactive sequencer.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[2]) |-> (!active_ff && !rsp_data_ff[1]
                                             && phase_ff == pwbs_pkg::PH_IDLE))
      else $error("done reported while sequencer still active");

   // The bit pointer never runs past the frame length.
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff < 4'(BITS_PER_FRAME))
      else $error("bit index out of range");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the pulse-width byte sender: tick stimulus, line prediction, checks.
module tb;

   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned HOLD_CYCLES = 60;

   typedef struct packed {
      logic done;
      logic busy;
      logic line;
   } tick_result_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic [pwbs_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [pwbs_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [pwbs_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [pwbs_pkg::CSR_DATA_W-1:0]   csr_data = '0;

   // Expected wire state per tick, in the order the ticks were accepted.
   tick_result_type expected_wire [$];
   int unsigned  fail_count = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  stall_left = 0;
   bit           no_idle = 1'b0;
   bit           hold_now = 1'b0;

   // Predicted state of the sender.
   logic [7:0]          timing_regs [8];
   pwbs_pkg::phase_type phase_q;
   logic [7:0]          tick_q;
   logic [3:0]          bit_q;
   logic [7:0]          rep_q;
   logic                sending;
   logic [7:0]          held_q;
   logic                line_q;

   pulse_width_byte_sender uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(10, 4);
      return $urandom_range(40, 15);
   endfunction

   function automatic void clear_sequence();
      phase_q = pwbs_pkg::PH_IDLE;
      tick_q = '0;
      bit_q = '0;
      rep_q = '0;
   endfunction

   function automatic tick_result_type advance_sender(logic start_bit, logic abort_bit,
                                                      logic [7:0] data_in);
      tick_result_type res;
      logic [7:0]      seg_end;
      res.done = 1'b0;
      if (abort_bit) begin
         sending = 1'b0;
      end else if (start_bit && !sending) begin
         sending = 1'b1;
         held_q = data_in;
      end
      if (!sending) begin
         clear_sequence();
      end else begin
         case (phase_q)
            pwbs_pkg::PH_IDLE: begin
               line_q = 1'b1;
               tick_q = '0;
               phase_q = pwbs_pkg::PH_START;
            end
            pwbs_pkg::PH_START: begin
               tick_q = tick_q + 8'd1;
               if (tick_q <= timing_regs[pwbs_pkg::REG_START_LOW]) begin
                  line_q = 1'b0;
               end else if (tick_q < timing_regs[pwbs_pkg::REG_START_TOTAL]) begin
                  line_q = 1'b1;
               end else begin
                  tick_q = '0;
                  bit_q = '0;
                  phase_q = pwbs_pkg::PH_DATA;
               end
            end
            pwbs_pkg::PH_DATA: begin
               tick_q = tick_q + 8'd1;
               if (tick_q <= timing_regs[pwbs_pkg::REG_BIT_LOW]) begin
                  line_q = 1'b0;
               end else begin
                  seg_end = held_q[bit_q[2:0]] ? timing_regs[pwbs_pkg::REG_ONE_TOTAL]
                                               : timing_regs[pwbs_pkg::REG_ZERO_TOTAL];
                  if (tick_q < seg_end) begin
                     line_q = 1'b1;
                  end else begin
                     tick_q = '0;
                     bit_q = bit_q + 4'd1;
                  end
               end
               if (bit_q >= pwbs_pkg::BITS_PER_FRAME) begin
                  bit_q = '0;
                  tick_q = '0;
                  phase_q = pwbs_pkg::PH_STOP;
               end
            end
            default: begin
               tick_q = tick_q + 8'd1;
               if (tick_q <= timing_regs[pwbs_pkg::REG_STOP_LOW]) begin
                  line_q = 1'b0;
               end else if (tick_q < timing_regs[pwbs_pkg::REG_STOP_TOTAL]) begin
                  line_q = 1'b1;
               end else begin
                  tick_q = '0;
                  rep_q = rep_q + 8'd1;
                  if (rep_q >= timing_regs[pwbs_pkg::REG_REPEATS]) begin
                     rep_q = '0;
                     sending = 1'b0;
                     res.done = 1'b1;
                  end
                  phase_q = pwbs_pkg::PH_IDLE;
               end
            end
         endcase
      end
      res.line = line_q;
      res.busy = sending;
      return res;
   endfunction

   task automatic send_tick(input logic start_bit, input logic abort_bit,
                            input logic [7:0] data_in);
      int unsigned gap;
      req_tdata <= pwbs_pkg::REQ_DATA_W'({data_in, abort_bit, start_bit});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_wire.push_back(advance_sender(start_bit, abort_bit, data_in));
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_ticks(input int unsigned count, input int unsigned abort_per_mille);
      logic start_bit;
      logic abort_bit;
      for (int unsigned n = 0; n < count; n++) begin
         start_bit = sending ? ($urandom_range(9) == 0) : ($urandom_range(2) == 0);
         abort_bit = $urandom_range(999) < abort_per_mille;
         send_tick(start_bit, abort_bit, 8'($urandom));
      end
   endtask

   // Stop offering ticks and wait for every outstanding beat so no result is outstanding.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_wire.size() != 0) @(posedge clock);
   endtask

   task automatic load_timing(input logic [7:0] start_low, input logic [7:0] start_total,
                              input logic [7:0] bit_low, input logic [7:0] one_total,
                              input logic [7:0] zero_total, input logic [7:0] stop_low,
                              input logic [7:0] stop_total, input logic [7:0] repeats);
      logic [7:0] vals [8];
      vals[pwbs_pkg::REG_START_LOW] = start_low;
      vals[pwbs_pkg::REG_START_TOTAL] = start_total;
      vals[pwbs_pkg::REG_BIT_LOW] = bit_low;
      vals[pwbs_pkg::REG_ONE_TOTAL] = one_total;
      vals[pwbs_pkg::REG_ZERO_TOTAL] = zero_total;
      vals[pwbs_pkg::REG_STOP_LOW] = stop_low;
      vals[pwbs_pkg::REG_STOP_TOTAL] = stop_total;
      vals[pwbs_pkg::REG_REPEATS] = repeats;
      settle();
      csr_valid <= 1'b1;
      for (int i = 0; i < 8; i++) begin
         csr_index <= pwbs_pkg::CSR_IDX_W'(i);
         csr_data <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         timing_regs[i] = vals[i];
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_timing();
      run_ticks(150, 2);
   endtask

   task automatic test_start_abort_rules();
      load_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_tick(1'b0, 1'b0, 8'hFF);
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b1, 1'b0, 8'hFF);
      repeat (12) send_tick(1'b0, 1'b0, 8'h00);
      send_tick(1'b1, 1'b1, 8'hFF);
      send_tick(1'b1, 1'b0, 8'hFF);
      repeat (3) send_tick(1'b0, 1'b0, 8'h00);
      send_tick(1'b0, 1'b1, 8'h00);
      send_tick(1'b0, 1'b1, 8'hFF);
      send_tick(1'b0, 1'b0, 8'h00);
   endtask

   // The receiver stops for a long stretch while ticks keep coming, so intake stalls.
   task automatic test_back_pressure();
      load_timing(8'd1, 8'd2, 8'd1, 8'd3, 8'd2, 8'd1, 8'd2, 8'd2);
      no_idle = 1'b1;
      send_tick(1'b1, 1'b0, 8'h5A);
      hold_now = 1'b1;
      run_ticks(40, 0);
      no_idle = 1'b0;
   endtask

   task automatic test_random_timing();
      for (int round = 0; round < 3; round++) begin
         load_timing(8'($urandom_range(12)), 8'($urandom_range(12)),
                     8'($urandom_range(12)), 8'($urandom_range(12)),
                     8'($urandom_range(12)), 8'($urandom_range(12)),
                     8'($urandom_range(12)), 8'($urandom_range(3)));
         no_idle = (round == 1);
         run_ticks(100, 3);
      end
      no_idle = 1'b0;
      load_timing(8'($urandom_range(40)), 8'($urandom_range(40)),
                  8'($urandom_range(40)), 8'($urandom_range(40)),
                  8'($urandom_range(40)), 8'($urandom_range(40)),
                  8'($urandom_range(40)), 8'd1);
      run_ticks(80, 2);
   endtask

   // With every register at its maximum the start signal never ends and the count wraps.
   task automatic test_count_wrap();
      load_timing(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_tick(1'b1, 1'b0, 8'($urandom));
      run_ticks(270, 0);
      send_tick(1'b0, 1'b1, 8'($urandom));
      load_timing(pwbs_pkg::RST_START_LOW, pwbs_pkg::RST_START_TOTAL,
                  pwbs_pkg::RST_BIT_LOW, pwbs_pkg::RST_ONE_TOTAL,
                  pwbs_pkg::RST_ZERO_TOTAL, pwbs_pkg::RST_STOP_LOW,
                  pwbs_pkg::RST_STOP_TOTAL, pwbs_pkg::RST_REPEATS);
   endtask

   always @(posedge clock) begin : rsp_side
      tick_result_type exp_res;
      int unsigned     gap;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_wire.size() == 0) begin
               $error("rsp beat 0x%0h arrived with no tick outstanding", rsp_tdata);
               fail_count++;
            end else begin
               exp_res = expected_wire.pop_front();
               if (rsp_tdata[0] !== exp_res.line) begin
                  $error("line_level: expected %0b, got %0b", exp_res.line, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[1] !== exp_res.busy) begin
                  $error("busy_res: expected %0b, got %0b", exp_res.busy, rsp_tdata[1]);
                  fail_count++;
               end
               if (rsp_tdata[2] !== exp_res.done) begin
                  $error("done_res: expected %0b, got %0b", exp_res.done, rsp_tdata[2]);
                  fail_count++;
               end
            end
         end
         if (hold_now) begin
            hold_now = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            gap = pick_gap();
            if (gap != 0) begin
               stall_left = gap - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      timing_regs[pwbs_pkg::REG_START_LOW] = pwbs_pkg::RST_START_LOW;
      timing_regs[pwbs_pkg::REG_START_TOTAL] = pwbs_pkg::RST_START_TOTAL;
      timing_regs[pwbs_pkg::REG_BIT_LOW] = pwbs_pkg::RST_BIT_LOW;
      timing_regs[pwbs_pkg::REG_ONE_TOTAL] = pwbs_pkg::RST_ONE_TOTAL;
      timing_regs[pwbs_pkg::REG_ZERO_TOTAL] = pwbs_pkg::RST_ZERO_TOTAL;
      timing_regs[pwbs_pkg::REG_STOP_LOW] = pwbs_pkg::RST_STOP_LOW;
      timing_regs[pwbs_pkg::REG_STOP_TOTAL] = pwbs_pkg::RST_STOP_TOTAL;
      timing_regs[pwbs_pkg::REG_REPEATS] = pwbs_pkg::RST_REPEATS;
      clear_sequence();
      sending = 1'b0;
      held_q = '0;
      line_q = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_timing();
      test_start_abort_rules();
      test_back_pressure();
      test_random_timing();
      test_count_wrap();
      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
